// File: rtl/pra_pkg.sv
// Shared types and constants of the packet ring queue.
package pra_pkg;

  localparam int SLOTS_DEFAULT      = 8;
  localparam int SLOT_BYTES_DEFAULT = 64;
  localparam int QUEUE_DEPTH        = 2;
  localparam int BYTE_W             = 8;
  localparam int COUNT_W            = 7;
  localparam int STATUS_W           = 3;

  typedef struct packed {
    logic                cmd;
    logic [BYTE_W-1:0]   data_in;
    logic                end_of_packet;
    logic [COUNT_W-1:0]  capacity;
  } item_t;

  typedef struct packed {
    logic [BYTE_W-1:0]   data_out;
    logic [COUNT_W-1:0]  byte_count;
    logic                last;
    logic [STATUS_W-1:0] status;
  } result_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_READ_BYTE = 3'd0,
    ST_EMPTY     = 3'd1,
    ST_WRITTEN   = 3'd2,
    ST_DROPPED   = 3'd3,
    ST_TRUNC     = 3'd4
  } status_t;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_READ  = 1'b1;

  typedef enum logic [1:0] {
    OP_WRITE,
    OP_WRITE_LAST,
    OP_READ,
    OP_READ_NONE
  } op_t;

  // Classified command handed from the front queue to the engine.
  typedef struct packed {
    op_t                op;
    logic [BYTE_W-1:0]  data;
    logic [COUNT_W-1:0] cap;
  } cmd_t;

  typedef enum logic [1:0] {
    ENG_IDLE,
    ENG_LEN,
    ENG_STREAM
  } eng_state_t;

endpackage

// File: rtl/pra_cmd_queue.sv
// Front part: classifies accepted commands and queues them for the engine.
module pra_cmd_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  pra_pkg::item_t  item,
  output logic            cmd_valid,
  output pra_pkg::cmd_t   cmd,
  input  logic            cmd_pop
);

  localparam int PTR_W = (pra_pkg::QUEUE_DEPTH > 1) ? $clog2(pra_pkg::QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(pra_pkg::QUEUE_DEPTH + 1);

  pra_pkg::cmd_t entries [pra_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr, wr_ptr_next;
  logic [PTR_W-1:0] rd_ptr, rd_ptr_next;
  logic [CNT_W-1:0] count, count_next;
  logic             push;
  logic             pop;
  pra_pkg::cmd_t    incoming;

  assign busy      = (count == CNT_W'(pra_pkg::QUEUE_DEPTH));
  assign cmd_valid = (count != '0);
  assign cmd       = entries[rd_ptr];
  assign push      = start && !busy;
  assign pop       = cmd_pop && cmd_valid;

  always_comb begin
    incoming.data = item.data_in;
    incoming.cap  = item.capacity;
    if (item.cmd == pra_pkg::CMD_READ) begin
      incoming.op = (item.capacity == '0) ? pra_pkg::OP_READ_NONE : pra_pkg::OP_READ;
    end else begin
      incoming.op = item.end_of_packet ? pra_pkg::OP_WRITE_LAST : pra_pkg::OP_WRITE;
    end
  end

  always_comb begin
    wr_ptr_next = wr_ptr;
    rd_ptr_next = rd_ptr;
    count_next  = count;
    if (push) begin
      wr_ptr_next = (wr_ptr == PTR_W'(pra_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
    end
    if (pop) begin
      rd_ptr_next = (rd_ptr == PTR_W'(pra_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
    end
    if (push && !pop) begin
      count_next = count + 1'b1;
    end else if (pop && !push) begin
      count_next = count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
      count  <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= incoming;
    end
  end

endmodule

// File: rtl/pra_engine.sv
// Back part: ring storage, packet assembly and streaming reads.
module pra_engine #(
  parameter int SLOTS      = pra_pkg::SLOTS_DEFAULT,
  parameter int SLOT_BYTES = pra_pkg::SLOT_BYTES_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cmd_valid,
  input  pra_pkg::cmd_t    cmd,
  output logic             cmd_pop,
  output logic             strobe,
  output pra_pkg::result_t result
);

  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int PCNT_W = $clog2(SLOTS + 1);
  localparam int CNT_W  = $clog2(SLOT_BYTES + 1);
  localparam int DEPTH  = SLOTS * SLOT_BYTES;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW     = pra_pkg::COUNT_W;

  logic [pra_pkg::BYTE_W-1:0] byte_store [DEPTH];
  logic [CNT_W-1:0]           slot_length [SLOTS];

  pra_pkg::eng_state_t state, state_next;

  logic [SLOT_W-1:0] head_index, head_index_next;
  logic [SLOT_W-1:0] tail_index, tail_index_next;
  logic [PCNT_W-1:0] packet_count, packet_count_next;
  logic [CNT_W-1:0]  head_offset, head_offset_next;
  logic [CNT_W-1:0]  fill_count, fill_count_next;
  logic              overflow_seen, overflow_seen_next;
  logic [CW-1:0]     cap_q, cap_q_next;
  logic [CNT_W-1:0]  rd_pos, rd_pos_next;
  logic [CNT_W-1:0]  rem, rem_next;
  logic [CNT_W-1:0]  n_q, n_q_next;
  logic              frees_q, frees_q_next;
  logic [CNT_W-1:0]  new_off_q, new_off_q_next;

  logic                         strobe_next;
  logic                         res_byte, res_byte_next;
  logic                         res_last, res_last_next;
  logic [CW-1:0]                res_count, res_count_next;
  logic [pra_pkg::STATUS_W-1:0] res_status, res_status_next;

  logic [pra_pkg::BYTE_W-1:0] rd_data;
  logic [CNT_W-1:0]           len_rd;
  logic [ADDR_W-1:0]          rd_addr, wr_addr;
  logic                       mem_we, len_we;
  logic [CNT_W-1:0]           rd_sel;

  logic              full, over;
  logic [CNT_W-1:0]  fill_inc;
  logic [CNT_W-1:0]  remain, n_len;
  logic              finish, finish_frees;
  logic [CNT_W-1:0]  finish_off;
  logic [SLOT_W-1:0] head_adv, tail_adv;

  assign full     = (packet_count == PCNT_W'(SLOTS));
  assign over     = full || (fill_count >= CNT_W'(SLOT_BYTES));
  assign fill_inc = fill_count + 1'b1;
  assign head_adv = (head_index == SLOT_W'(SLOTS - 1)) ? '0 : head_index + 1'b1;
  assign tail_adv = (tail_index == SLOT_W'(SLOTS - 1)) ? '0 : tail_index + 1'b1;

  // Bytes left in the head packet, clipped by the request capacity.
  assign remain = (head_offset < len_rd) ? len_rd - head_offset : '0;
  assign n_len  = (CW'(remain) < cap_q) ? remain : CNT_W'(cap_q);

  assign rd_sel  = (state == pra_pkg::ENG_LEN) ? head_offset : rd_pos;
  assign rd_addr = ADDR_W'(head_index) * ADDR_W'(SLOT_BYTES) + ADDR_W'(rd_sel);
  assign wr_addr = ADDR_W'(tail_index) * ADDR_W'(SLOT_BYTES) + ADDR_W'(fill_count);

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      pra_pkg::ENG_IDLE: begin
        if (cmd_valid && cmd.op == pra_pkg::OP_READ && packet_count != '0) begin
          state_next = pra_pkg::ENG_LEN;
        end
      end
      pra_pkg::ENG_LEN: begin
        state_next = (n_len > CNT_W'(1)) ? pra_pkg::ENG_STREAM : pra_pkg::ENG_IDLE;
      end
      pra_pkg::ENG_STREAM: begin
        if (rem == CNT_W'(1)) begin
          state_next = pra_pkg::ENG_IDLE;
        end
      end
      default: state_next = pra_pkg::ENG_IDLE;
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    head_index_next    = head_index;
    tail_index_next    = tail_index;
    packet_count_next  = packet_count;
    head_offset_next   = head_offset;
    fill_count_next    = fill_count;
    overflow_seen_next = overflow_seen;
    cap_q_next         = cap_q;
    rd_pos_next        = rd_pos;
    rem_next           = rem;
    n_q_next           = n_q;
    frees_q_next       = frees_q;
    new_off_q_next     = new_off_q;
    strobe_next        = 1'b0;
    res_byte_next      = 1'b0;
    res_last_next      = 1'b1;
    res_count_next     = '0;
    res_status_next    = pra_pkg::ST_EMPTY;
    cmd_pop            = 1'b0;
    mem_we             = 1'b0;
    len_we             = 1'b0;
    finish             = 1'b0;
    finish_frees       = frees_q;
    finish_off         = new_off_q;

    case (state)
      pra_pkg::ENG_IDLE: begin
        if (cmd_valid) begin
          cmd_pop = 1'b1;
          case (cmd.op)
            pra_pkg::OP_WRITE, pra_pkg::OP_WRITE_LAST: begin
              if (over) begin
                overflow_seen_next = 1'b1;
              end else begin
                mem_we          = 1'b1;
                fill_count_next = fill_inc;
              end
              if (cmd.op == pra_pkg::OP_WRITE_LAST) begin
                strobe_next        = 1'b1;
                fill_count_next    = '0;
                overflow_seen_next = 1'b0;
                if (full) begin
                  res_status_next = pra_pkg::ST_DROPPED;
                end else begin
                  len_we            = 1'b1;
                  tail_index_next   = tail_adv;
                  packet_count_next = packet_count + 1'b1;
                  res_count_next    = over ? CW'(fill_count) : CW'(fill_inc);
                  res_status_next   = (overflow_seen || over) ? pra_pkg::ST_TRUNC
                                                              : pra_pkg::ST_WRITTEN;
                end
              end
            end
            pra_pkg::OP_READ: begin
              cap_q_next = cmd.cap;
              if (packet_count == '0) begin
                strobe_next = 1'b1;
              end
            end
            default: begin
              strobe_next = 1'b1;
            end
          endcase
        end
      end
      pra_pkg::ENG_LEN: begin
        strobe_next    = 1'b1;
        frees_q_next   = (n_len == remain);
        new_off_q_next = head_offset + n_len;
        if (n_len == '0) begin
          // Head packet has nothing left: free it, answer empty.
          finish       = 1'b1;
          finish_frees = 1'b1;
        end else begin
          res_byte_next   = 1'b1;
          res_status_next = pra_pkg::ST_READ_BYTE;
          res_last_next   = (n_len == CNT_W'(1));
          res_count_next  = (n_len == CNT_W'(1)) ? CW'(n_len) : '0;
          rd_pos_next     = head_offset + 1'b1;
          rem_next        = n_len - 1'b1;
          n_q_next        = n_len;
          if (n_len == CNT_W'(1)) begin
            finish       = 1'b1;
            finish_frees = (n_len == remain);
            finish_off   = head_offset + n_len;
          end
        end
      end
      pra_pkg::ENG_STREAM: begin
        strobe_next     = 1'b1;
        res_byte_next   = 1'b1;
        res_status_next = pra_pkg::ST_READ_BYTE;
        res_last_next   = (rem == CNT_W'(1));
        res_count_next  = (rem == CNT_W'(1)) ? CW'(n_q) : '0;
        rd_pos_next     = rd_pos + 1'b1;
        rem_next        = rem - 1'b1;
        finish          = (rem == CNT_W'(1));
      end
      default: begin
      end
    endcase

    if (finish) begin
      if (finish_frees) begin
        head_offset_next  = '0;
        head_index_next   = head_adv;
        packet_count_next = packet_count - 1'b1;
      end else begin
        head_offset_next = finish_off;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= pra_pkg::ENG_IDLE;
      head_index    <= '0;
      tail_index    <= '0;
      packet_count  <= '0;
      head_offset   <= '0;
      fill_count    <= '0;
      overflow_seen <= 1'b0;
      strobe        <= 1'b0;
    end else begin
      state         <= state_next;
      head_index    <= head_index_next;
      tail_index    <= tail_index_next;
      packet_count  <= packet_count_next;
      head_offset   <= head_offset_next;
      fill_count    <= fill_count_next;
      overflow_seen <= overflow_seen_next;
      strobe        <= strobe_next;
    end
  end

  always_ff @(posedge clk) begin
    cap_q      <= cap_q_next;
    rd_pos     <= rd_pos_next;
    rem        <= rem_next;
    n_q        <= n_q_next;
    frees_q    <= frees_q_next;
    new_off_q  <= new_off_q_next;
    res_byte   <= res_byte_next;
    res_last   <= res_last_next;
    res_count  <= res_count_next;
    res_status <= res_status_next;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      byte_store[wr_addr] <= cmd.data;
    end
    rd_data <= byte_store[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (len_we) begin
      slot_length[tail_index] <= over ? fill_count : fill_inc;
    end
    len_rd <= slot_length[head_index];
  end

  assign result.data_out   = res_byte ? rd_data : '0;
  assign result.byte_count = res_count;
  assign result.last       = res_last;
  assign result.status     = res_status;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    packet_count <= PCNT_W'(SLOTS))
    else $error("packet count beyond ring size");

  a_offset_bound: assert property (@(posedge clk) disable iff (rst)
    head_offset < CNT_W'(SLOT_BYTES) || SLOT_BYTES == 1 && head_offset == '0)
    else $error("head offset past slot end");

  a_stream_rem: assert property (@(posedge clk) disable iff (rst)
    state == pra_pkg::ENG_STREAM |-> rem != '0)
    else $error("streaming with no bytes left");

  a_byte_source: assert property (@(posedge clk) disable iff (rst)
    strobe_next && res_byte_next |-> state != pra_pkg::ENG_IDLE && !cmd_pop)
    else $error("read byte issued while taking a command");

  a_no_pop_busy: assert property (@(posedge clk) disable iff (rst)
    state != pra_pkg::ENG_IDLE |-> !cmd_pop)
    else $error("command taken while a read streams");

endmodule

// File: rtl/packet_ring_queue_partial_read.sv
// Top level of the packet ring queue: command queue in front of the ring engine.
// A ring of SLOTS packet slots of SLOT_BYTES bytes each. Commands are taken when
// start is high and busy is low; a two-entry command queue sits in front of the
// engine, and busy rises only when that queue is full. The engine takes a write
// byte in its idle state; the byte marked end_of_packet yields one status result
// in the cycle after the engine takes it. A read of n bytes first looks up the
// head packet's length in the length memory, then gives one byte result per
// cycle from the byte memory's single read port; an empty read (no packet, or
// capacity zero) yields one result. Results appear on result for exactly one
// cycle with strobe high and cannot be held off, so the receiver must take
// every strobed beat.
module packet_ring_queue_partial_read #(
  parameter int SLOTS      = pra_pkg::SLOTS_DEFAULT,
  parameter int SLOT_BYTES = pra_pkg::SLOT_BYTES_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  pra_pkg::item_t   item,
  output logic             strobe,
  output pra_pkg::result_t result
);

  logic          cmd_valid;
  logic          cmd_pop;
  pra_pkg::cmd_t cmd;

  pra_cmd_queue u_front (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .item      (item),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  pra_engine #(
    .SLOTS      (SLOTS),
    .SLOT_BYTES (SLOT_BYTES)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .strobe    (strobe),
    .result    (result)
  );

endmodule

// File: dv/ring_check_pkg.sv
// Scoreboard class for the packet ring queue: predicts results and checks them in order.
package ring_check_pkg;

  class ring_scoreboard #(int NSLOTS = 8, int NBYTES = 64);
    logic [pra_pkg::BYTE_W-1:0] slot_bytes [NSLOTS*NBYTES];
    int unsigned                slot_len [NSLOTS];
    int unsigned                head_slot, tail_slot, packets_held, read_pos, fill_bytes;
    bit                         bytes_lost;
    pra_pkg::result_t           pending_results [$];
    int unsigned                errors, checked, beats_in;
    int unsigned                n_written, n_trunc, n_dropped, n_empty, n_bytes_out;

    function new();
      foreach (slot_bytes[i]) slot_bytes[i] = '0;
      foreach (slot_len[i]) slot_len[i] = 0;
      head_slot    = 0;
      tail_slot    = 0;
      packets_held = 0;
      read_pos     = 0;
      fill_bytes   = 0;
      bytes_lost   = 1'b0;
    endfunction

    function int unsigned step_slot(int unsigned s);
      return (s + 1 >= NSLOTS) ? 0 : s + 1;
    endfunction

    function int unsigned pending();
      return pending_results.size();
    endfunction

    function void expect_result(logic [pra_pkg::BYTE_W-1:0] data, int unsigned count,
                                logic fin, pra_pkg::status_t st);
      pra_pkg::result_t r;
      r.data_out   = data;
      r.byte_count = pra_pkg::COUNT_W'(count);
      r.last       = fin;
      r.status     = st;
      pending_results.push_back(r);
      case (st)
        pra_pkg::ST_WRITTEN:   n_written++;
        pra_pkg::ST_TRUNC:     n_trunc++;
        pra_pkg::ST_DROPPED:   n_dropped++;
        pra_pkg::ST_EMPTY:     n_empty++;
        pra_pkg::ST_READ_BYTE: n_bytes_out++;
        default: ;
      endcase
    endfunction

    function void write_byte(logic [pra_pkg::BYTE_W-1:0] data, logic eop);
      bit          full;
      int unsigned len;
      full = packets_held >= NSLOTS;
      // Drop the byte when the tail slot is still occupied or already filled.
      if (full || fill_bytes >= NBYTES) begin
        bytes_lost = 1'b1;
      end else begin
        slot_bytes[tail_slot*NBYTES + fill_bytes] = data;
        fill_bytes++;
      end
      if (!eop) return;
      if (full) begin
        expect_result('0, 0, 1'b1, pra_pkg::ST_DROPPED);
      end else begin
        len = fill_bytes;
        slot_len[tail_slot] = len;
        tail_slot = step_slot(tail_slot);
        packets_held++;
        expect_result('0, len, 1'b1, bytes_lost ? pra_pkg::ST_TRUNC : pra_pkg::ST_WRITTEN);
      end
      fill_bytes = 0;
      bytes_lost = 1'b0;
    endfunction

    function void read_packet(int unsigned cap);
      int unsigned len, remain, n, pos;
      logic [pra_pkg::BYTE_W-1:0] b;
      if (cap == 0 || packets_held == 0) begin
        expect_result('0, 0, 1'b1, pra_pkg::ST_EMPTY);
        return;
      end
      len    = slot_len[head_slot];
      remain = (read_pos < len) ? len - read_pos : 0;
      n      = (remain < cap) ? remain : cap;
      if (n > NBYTES) n = NBYTES;
      for (int unsigned i = 0; i < n; i++) begin
        pos = read_pos + i;
        b   = (pos < NBYTES) ? slot_bytes[head_slot*NBYTES + pos] : '0;
        expect_result(b, (i + 1 == n) ? n : 0, i + 1 == n, pra_pkg::ST_READ_BYTE);
      end
      read_pos += n;
      // Free the slot once the packet has been read to its end.
      if (read_pos >= len) begin
        read_pos  = 0;
        head_slot = step_slot(head_slot);
        packets_held--;
      end
      if (n == 0) expect_result('0, 0, 1'b1, pra_pkg::ST_EMPTY);
    endfunction

    function void note_item(pra_pkg::item_t it);
      beats_in++;
      if (it.cmd == pra_pkg::CMD_WRITE) write_byte(it.data_in, it.end_of_packet);
      else read_packet(it.capacity);
    endfunction

    function void check_result(pra_pkg::result_t got);
      pra_pkg::result_t want;
      if (pending_results.size() == 0) begin
        if (errors < 10)
          $display("%0t: unexpected result data=%02h count=%0d last=%0b status=%0d",
                   $realtime, got.data_out, got.byte_count, got.last, got.status);
        errors++;
        return;
      end
      want = pending_results.pop_front();
      checked++;
      if (got.data_out !== want.data_out || got.byte_count !== want.byte_count ||
          got.last !== want.last || got.status !== want.status) begin
        if (errors < 10)
          $display({"%0t: mismatch exp data=%02h count=%0d last=%0b status=%0d, ",
                    "got data=%02h count=%0d last=%0b status=%0d"},
                   $realtime, want.data_out, want.byte_count, want.last, want.status,
                   got.data_out, got.byte_count, got.last, got.status);
        errors++;
      end
    endfunction
  endclass

endpackage

// File: dv/tb_top.sv
// Top-level testbench of the packet ring queue: clock, reset, stimulus, checking.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS        = 8;
  localparam int SLOT_BYTES   = 64;
  localparam int RANDOM_BEATS = 136;
  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 100;

  logic             clk   = 1'b0;
  logic             rst   = 1'b1;
  logic             start = 1'b0;
  pra_pkg::item_t   item  = '0;
  logic             busy;
  logic             strobe;
  pra_pkg::result_t result;

  ring_check_pkg::ring_scoreboard #(SLOTS, SLOT_BYTES) sb = new();

  int unsigned burst_left  = 0;
  int unsigned beats_sent  = 0;
  int unsigned idle_cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  packet_ring_queue_partial_read #(
    .SLOTS      (SLOTS),
    .SLOT_BYTES (SLOT_BYTES)
  ) u_dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .item   (item),
    .strobe (strobe),
    .result (result)
  );

  always @(posedge clk) begin
    if (!rst && strobe) sb.check_result(result);
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || strobe) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no beat moved for %0d cycles", $realtime, IDLE_LIMIT);
      $display("Test completed with failures");
      $finish;
    end
  end

  // Hold the beat until busy is low at a rising edge, then, when a burst ends, possibly insert a gap.
  task automatic send_beat(input pra_pkg::item_t it);
    int unsigned gap;
    item  <= it;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_item(it);
    beats_sent++;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end else begin
      burst_left--;
    end
  endtask

  task automatic put_byte(input logic [pra_pkg::BYTE_W-1:0] data, input logic eop);
    pra_pkg::item_t it;
    it.cmd           = pra_pkg::CMD_WRITE;
    it.data_in       = data;
    it.end_of_packet = eop;
    it.capacity      = pra_pkg::COUNT_W'($urandom_range(0, 64));
    send_beat(it);
  endtask

  task automatic ask_read(input int unsigned cap);
    pra_pkg::item_t it;
    it.cmd           = pra_pkg::CMD_READ;
    it.data_in       = pra_pkg::BYTE_W'($urandom_range(0, 255));
    it.end_of_packet = 1'($urandom_range(0, 1));
    it.capacity      = pra_pkg::COUNT_W'(cap);
    send_beat(it);
  endtask

  function automatic int unsigned pick_cap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10) return 0;
    if (r < 25) return 64;
    if (r < 35) return $urandom_range(13, 63);
    return $urandom_range(1, 12);
  endfunction

  // Reads may slip in between the bytes of a packet being written.
  task automatic put_packet(input int unsigned len, input bit mix_reads);
    for (int unsigned i = 0; i < len; i++) begin
      if (mix_reads && i != 0 && $urandom_range(0, 9) == 0) ask_read(pick_cap());
      put_byte(pra_pkg::BYTE_W'($urandom_range(0, 255)), i + 1 == len);
    end
  endtask

  initial begin
    logic [pra_pkg::BYTE_W-1:0] edge_bytes [8];
    int unsigned                random_from;
    bit                         write_heavy;
    bit                         long_done;

    edge_bytes  = '{8'h00, 8'hFF, 8'hA5, 8'h5A, 8'h01, 8'h80, 8'h7F, 8'hFE};
    write_heavy = 1'b1;
    long_done   = 1'b0;

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Empty ring, then zero capacity.
    ask_read(5);
    ask_read(0);
    // Fill every slot with one-byte packets, then overflow the ring.
    foreach (edge_bytes[i]) put_byte(edge_bytes[i], 1'b1);
    put_byte(8'hFF, 1'b1);
    ask_read(0);
    ask_read(64);
    put_byte(8'h11, 1'b0);
    put_byte(8'h22, 1'b0);
    put_byte(8'h33, 1'b1);
    // Lose a byte while full, free a slot, then commit: marked truncated.
    put_byte(8'h44, 1'b0);
    ask_read(1);
    put_byte(8'h55, 1'b1);
    ask_read(2);
    ask_read(64);
    ask_read(1);
    ask_read(3);

    random_from = beats_sent;
    while (beats_sent - random_from < RANDOM_BEATS) begin
      if ($urandom_range(0, 5) == 0) write_heavy = !write_heavy;
      if (!long_done && beats_sent - random_from >= 50) begin
        put_packet(SLOT_BYTES + 1 + $urandom_range(0, 3), 1'b0);
        long_done = 1'b1;
      end else if ($urandom_range(0, 99) < (write_heavy ? 70 : 30)) begin
        put_packet($urandom_range(1, 8), 1'b1);
      end else begin
        ask_read(pick_cap());
      end
    end
    start <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d beats, checked %0d results: %0d written, %0d truncated, %0d dropped",
             sb.beats_in, sb.checked, sb.n_written, sb.n_trunc, sb.n_dropped);
    $display("Empty reads %0d, packet bytes read back %0d, mismatches %0d",
             sb.n_empty, sb.n_bytes_out, sb.errors);
    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
